// ===== hdl/porc4_pkg.sv =====
package porc4_pkg;

    localparam int unsigned KeyRegs = 3;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_MODE = 2'd2;

    localparam logic [31:0] MD5_H0 = 32'h67452301;
    localparam logic [31:0] MD5_H1 = 32'hEFCDAB89;
    localparam logic [31:0] MD5_H2 = 32'h98BADCFE;
    localparam logic [31:0] MD5_H3 = 32'h10325476;

    // md5 start/done handshake between sequencer and hash unit
    typedef struct packed {
        logic start;
        logic done;
    } md5_ctl_t;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== hdl/porc4_md5.sv =====
// One MD5 round per cycle over a single padded block.
module porc4_md5 import porc4_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [511:0] block,
    output logic         done,
    output logic [127:0] digest
);
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  r_reg;
    logic        busy_reg, done_reg;
    logic [31:0] f, t, rot, m_word;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [31:0] h0, h1, h2, h3;

    always_comb begin
        case (r_reg[5:4])
            2'd0: begin f = d_reg ^ (b_reg & (c_reg ^ d_reg)); g = r_reg[3:0]; end
            2'd1: begin
                f = c_reg ^ (d_reg & (b_reg ^ c_reg));
                g = 4'(({r_reg[3:0], 2'b00}) + r_reg[3:0] + 4'd1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(({r_reg[3:0], 1'b0}) + r_reg[3:0] + 4'd5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(({r_reg[3:0], 3'b000}) - r_reg[3:0]);
            end
        endcase
        m_word = block[{g, 5'd0} +: 32];
        s = md5_rot(r_reg);
        t = f + a_reg + md5_k(r_reg) + m_word;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        h0 = MD5_H0 + a_reg;
        h1 = MD5_H1 + b_reg;
        h2 = MD5_H2 + c_reg;
        h3 = MD5_H3 + d_reg;
    end

    assign digest = {h3, h2, h1, h0};
    assign done   = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            r_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                r_reg    <= '0;
                a_reg <= MD5_H0; b_reg <= MD5_H1; c_reg <= MD5_H2; d_reg <= MD5_H3;
            end else if (busy_reg) begin
                a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                b_reg <= b_reg + rot;
                r_reg <= r_reg + 6'd1;
                if (r_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/pdf_object_rc4_decrypt.sv =====
// Per-object RC4 cipher for PDF string and stream bytes. Each request is one
// byte and yields one byte. A request with first_of_object set (and
// pass_through clear) derives the object key: base key, object and
// generation bytes go through one MD5 block (one round per cycle in the hash
// unit), then the key schedule fills the 256-entry S-box and permutes it
// (256 swaps, each as read S[k], read S[j], write S[k], write S[j], limited
// by the single-port S-box RAM), all before the byte itself.
// A keyed byte steps through S-box access in order (read i, read j, write i,
// write j, read output entry, capture it); a pass-through or not-yet-keyed
// byte goes straight to the output register. The new j is formed from the
// registered read data and drives the RAM address in the same cycle, so the
// swap reads the right entry.
// The block is not ready while a request is in work or its result waits on
// m_ready. Key registers are sampled only when an object starts.
module pdf_object_rc4_decrypt import porc4_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_object,
    input  logic [23:0] s_object_number,
    input  logic [15:0] s_generation_number,
    input  logic        s_pass_through,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_HASH  = 4'd1;
    localparam logic [3:0] ST_FILL  = 4'd2;
    localparam logic [3:0] ST_KRD   = 4'd3;  // read S[k]
    localparam logic [3:0] ST_KRJ   = 4'd4;  // read S[j]
    localparam logic [3:0] ST_KWR   = 4'd5;  // write S[k] with S[j]; old S[k] into S[j] next
    localparam logic [3:0] ST_KWJ   = 4'd6;
    localparam logic [3:0] ST_BRI   = 4'd7;  // byte: read S[i]
    localparam logic [3:0] ST_BRJ   = 4'd8;
    localparam logic [3:0] ST_BWI   = 4'd9;
    localparam logic [3:0] ST_BWJ   = 4'd10;
    localparam logic [3:0] ST_BOUT  = 4'd11;
    localparam logic [3:0] ST_BDAT  = 4'd12;
    localparam logic [3:0] ST_HOLD  = 4'd13;

    logic [63:0]  key_low_reg, key_high_reg;
    logic         key_mode_reg;
    logic [3:0]   state_reg;
    logic [7:0]   data_reg;
    logic [7:0]   out_reg;
    logic [7:0]   i_reg, j_reg, k_reg;
    logic [7:0]   ti_reg, tj_reg;
    logic [3:0]   kidx_reg;
    logic         keyed_reg;
    logic         mode_now_reg;
    logic [511:0] block_reg;
    logic [127:0] digest, digest_reg;
    md5_ctl_t     md5_ctl;

    // single-port S-box RAM, registered read
    logic [7:0] sbox [256];
    logic [7:0] ram_addr, ram_wdata, ram_rdata;
    logic       ram_we;

    always_ff @(posedge aclk) begin
        if (ram_we) sbox[ram_addr] <= ram_wdata;
        ram_rdata <= sbox[ram_addr];
    end

    porc4_md5 u_md5 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md5_ctl.start),
        .block   (block_reg),
        .done    (md5_ctl.done),
        .digest  (digest)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_HOLD);
    assign m_out_byte = out_reg;
    assign md5_ctl.start = (state_reg == ST_IDLE) && s_valid && !s_pass_through
                           && s_first_of_object;

    // padded message block built at object start
    logic [511:0] blk;
    always_comb begin
        blk = '0;
        if (key_mode_reg) begin
            blk[127:0]   = {key_high_reg, key_low_reg};
            blk[151:128] = s_object_number;
            blk[167:152] = s_generation_number;
            blk[175:168] = 8'h80;
            blk[455:448] = 8'd168;
        end else begin
            blk[39:0]    = key_low_reg[39:0];
            blk[63:40]   = s_object_number;
            blk[79:64]   = s_generation_number;
            blk[87:80]   = 8'h80;
            blk[455:448] = 8'd80;
        end
    end

    logic [7:0] key_byte;
    assign key_byte = digest_reg[{kidx_reg, 3'd0} +: 8];

    // next j: S[k] or S[i] just read, plus key byte during the key schedule
    logic [7:0] j_step;
    always_comb begin
        j_step = j_reg + ram_rdata + ((state_reg == ST_KRJ) ? key_byte : 8'd0);
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = k_reg;
        ram_wdata = '0;
        unique case (state_reg)
            ST_FILL: begin ram_we = 1'b1; ram_addr = k_reg; ram_wdata = k_reg; end
            ST_KRD:  ram_addr = k_reg;
            ST_KRJ:  ram_addr = j_step;
            ST_KWR:  begin ram_we = 1'b1; ram_addr = k_reg; ram_wdata = ram_rdata; end
            ST_KWJ:  begin ram_we = 1'b1; ram_addr = j_reg; ram_wdata = ti_reg; end
            ST_BRI:  ram_addr = i_reg;
            ST_BRJ:  ram_addr = j_step;
            ST_BWI:  begin ram_we = 1'b1; ram_addr = i_reg; ram_wdata = ram_rdata; end
            ST_BWJ:  begin ram_we = 1'b1; ram_addr = j_reg; ram_wdata = ti_reg; end
            ST_BOUT: ram_addr = 8'(ti_reg + tj_reg);
            default: ram_addr = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_MODE: key_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            keyed_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            kidx_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_valid) begin
                    data_reg <= s_data_byte;
                    if (s_pass_through || (!s_first_of_object && !keyed_reg)) begin
                        out_reg   <= s_data_byte;
                        state_reg <= ST_HOLD;
                    end else if (s_first_of_object) begin
                        block_reg    <= blk;
                        mode_now_reg <= key_mode_reg;
                        state_reg    <= ST_HASH;
                    end else begin
                        i_reg     <= i_reg + 8'd1;
                        state_reg <= ST_BRI;
                    end
                end
                ST_HASH: if (md5_ctl.done) begin
                    digest_reg <= digest;
                    k_reg      <= '0;
                    state_reg  <= ST_FILL;
                end
                ST_FILL: begin
                    k_reg <= k_reg + 8'd1;
                    if (k_reg == 8'd255) begin
                        j_reg     <= '0;
                        kidx_reg  <= '0;
                        state_reg <= ST_KRD;
                    end
                end
                ST_KRD: state_reg <= ST_KRJ;
                ST_KRJ: begin
                    // ram_rdata = S[k]; new j addresses the RAM this cycle
                    ti_reg    <= ram_rdata;
                    j_reg     <= j_step;
                    kidx_reg  <= ((mode_now_reg && kidx_reg == 4'd15) ||
                                  (!mode_now_reg && kidx_reg == 4'd9)) ? 4'd0 : kidx_reg + 4'd1;
                    state_reg <= ST_KWR;
                end
                ST_KWR: state_reg <= ST_KWJ;
                ST_KWJ: begin
                    k_reg <= k_reg + 8'd1;
                    if (k_reg == 8'd255) begin
                        keyed_reg <= 1'b1;
                        i_reg     <= 8'd1;
                        j_reg     <= '0;
                        state_reg <= ST_BRI;
                    end else begin
                        state_reg <= ST_KRD;
                    end
                end
                ST_BRI: state_reg <= ST_BRJ;
                ST_BRJ: begin
                    ti_reg    <= ram_rdata;
                    j_reg     <= j_step;
                    state_reg <= ST_BWI;
                end
                ST_BWI: begin
                    tj_reg    <= ram_rdata;  // old S[j], now S[i]
                    state_reg <= ST_BWJ;
                end
                ST_BWJ: state_reg <= ST_BOUT;
                ST_BOUT: state_reg <= ST_BDAT;
                ST_BDAT: begin
                    out_reg   <= data_reg ^ ram_rdata;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Hash start only from idle with an object start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        md5_ctl.start |-> s_ready && s_first_of_object) else $error("md5 start");
    // Results only come after leaving idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) != ST_HOLD) else $error("m_valid rise");
    // Hash done only while waiting on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        md5_ctl.done |-> state_reg == ST_HASH) else $error("md5 done");
    // Byte cipher never runs unkeyed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BOUT |-> keyed_reg) else $error("unkeyed");
endmodule

// ===== tb/pdf_object_rc4_decrypt_test.sv =====
module pdf_object_rc4_decrypt_test;
    import porc4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // stall budget: covers a full rekey plus random stalls on both sides
    localparam int unsigned STALL_LIMIT = 40000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;  // unmapped index, write is dropped

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic [23:0] obj;
        logic [15:0] gen;
        logic        pass;
    } byte_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_first_of_object = 1'b0;
    logic [23:0] s_object_number = '0;
    logic [15:0] s_generation_number = '0;
    logic        s_pass_through = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;

    pdf_object_rc4_decrypt dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .s_first_of_object(s_first_of_object),
        .s_object_number(s_object_number),
        .s_generation_number(s_generation_number),
        .s_pass_through(s_pass_through),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_byte(m_out_byte)
    );

    always #1 aclk = ~aclk;

    byte_req_t   pending_bytes[$];
    logic [7:0]  cipher_bytes[$];   // predicted out_byte, oldest first
    int unsigned errors = 0;
    int unsigned stall_cycles = 0;
    logic        took_req = 1'b0;
    logic        running = 1'b0;
    logic        calm = 1'b0;       // no idling on either side while set

    // predictor state and its copy of the key registers
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic        wide_key = 1'b0;
    logic [7:0]  sbox[256];
    logic [7:0]  ri = '0;
    logic [7:0]  rj = '0;
    logic        have_key = 1'b0;
    logic [31:0] sine_k[64];
    logic [4:0]  shift_amt[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // object key: MD5 of base key || obj[2:0] || gen[1:0], then RC4 key schedule
    task automatic rekey_object(input logic [23:0] obj, input logic [15:0] gen);
        logic [7:0]  blk[64];
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t, h0, h1, h2, h3;
        logic [7:0]  digest[16];
        logic [7:0]  j, tmp;
        logic [15:0] nbits;
        int          n, len, g, keylen;
        for (int k = 0; k < 64; k++) blk[k] = 8'h00;
        n = wide_key ? 16 : 5;
        keylen = wide_key ? 16 : 10;
        for (int k = 0; k < n; k++)
            blk[k] = (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
        blk[n]   = obj[7:0];
        blk[n+1] = obj[15:8];
        blk[n+2] = obj[23:16];
        blk[n+3] = gen[7:0];
        blk[n+4] = gen[15:8];
        len = n + 5;
        blk[len] = 8'h80;
        nbits = 16'(len * 8);
        blk[56] = nbits[7:0];
        blk[57] = nbits[15:8];
        for (int k = 0; k < 16; k++)
            w[k] = {blk[4*k+3], blk[4*k+2], blk[4*k+1], blk[4*k]};
        h0 = MD5_H0; h1 = MD5_H1; h2 = MD5_H2; h3 = MD5_H3;
        a = h0; b = h1; c = h2; d = h3;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = d ^ (b & (c ^ d)); g = r;
            end else if (r < 32) begin
                f = c ^ (d & (b ^ c)); g = (5*r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d; g = (3*r + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7*r) % 16;
            end
            t = f + a + sine_k[r] + w[g];
            a = d; d = c; c = b;
            b = b + ((t << shift_amt[(r/16)*4 + r%4]) | (t >> (32 - shift_amt[(r/16)*4 + r%4])));
        end
        h0 += a; h1 += b; h2 += c; h3 += d;
        for (int k = 0; k < 4; k++) begin
            digest[k]    = h0[8*k +: 8];
            digest[k+4]  = h1[8*k +: 8];
            digest[k+8]  = h2[8*k +: 8];
            digest[k+12] = h3[8*k +: 8];
        end
        for (int k = 0; k < 256; k++) sbox[k] = k[7:0];
        j = 8'd0;
        for (int k = 0; k < 256; k++) begin
            tmp = sbox[k];
            j = j + tmp + digest[k % keylen];
            sbox[k] = sbox[j];
            sbox[j] = tmp;
        end
        ri = 8'd0;
        rj = 8'd0;
        have_key = 1'b1;
    endtask

    task automatic predict_byte(input byte_req_t r);
        logic [7:0] tmp;
        if (r.pass) begin
            cipher_bytes.push_back(r.data);
        end else begin
            if (r.first) rekey_object(r.obj, r.gen);
            if (!have_key) begin
                cipher_bytes.push_back(r.data);
            end else begin
                ri = ri + 8'd1;
                tmp = sbox[ri];
                rj = rj + tmp;
                sbox[ri] = sbox[rj];
                sbox[rj] = tmp;
                cipher_bytes.push_back(r.data ^ sbox[sbox[ri] + sbox[rj]]);
            end
        end
    endtask

    // request driver: new request only after the previous one was taken
    always @(negedge aclk) begin
        if (running && (!s_valid || took_req)) begin
            if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
                byte_req_t r;
                r = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= r.data;
                s_first_of_object <= r.first;
                s_object_number <= r.obj;
                s_generation_number <= r.gen;
                s_pass_through <= r.pass;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (running) m_ready <= calm || ($urandom_range(99) >= 11);
    end

    // accept, predict, check, watchdog
    always @(posedge aclk) begin
        took_req <= s_valid && s_ready;
        if (s_valid && s_ready)
            predict_byte('{s_data_byte, s_first_of_object, s_object_number,
                           s_generation_number, s_pass_through});
        if (m_valid && m_ready) begin
            if (cipher_bytes.size() == 0) begin
                $display("%t: unexpected out_byte: expected none, actual %02h",
                         $realtime, m_out_byte);
                errors++;
            end else begin
                logic [7:0] want;
                want = cipher_bytes.pop_front();
                if (m_out_byte !== want) begin
                    $display("%t: out_byte mismatch: expected %02h, actual %02h",
                             $realtime, want, m_out_byte);
                    errors++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%t: watchdog expired", $realtime);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // register write while idle; predictor copy follows at once
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_LOW:  key_lo = val;
            CFG_KEY_HIGH: key_hi = val;
            CFG_KEY_MODE: wide_key = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_bytes.size() == 0 && !s_valid && cipher_bytes.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_req(input logic [7:0] data, input logic first,
                            input logic [23:0] obj, input logic [15:0] gen,
                            input logic pass);
        pending_bytes.push_back('{data, first, obj, gen, pass});
    endtask

    // mostly well-formed objects: first byte, then body; some pass-through
    // objects and a little noise (stray first/pass bits)
    task automatic push_objects(input int unsigned count);
        int unsigned sent, len;
        logic pass_obj;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(300, 280) : $urandom_range(40, 1);
            pass_obj = ($urandom_range(9) == 0);
            push_req($urandom(), 1'b1, $urandom(), $urandom(), pass_obj);
            for (int k = 1; k < len; k++)
                push_req($urandom(), ($urandom_range(49) == 0), $urandom(), $urandom(),
                         pass_obj | ($urandom_range(19) == 0));
            sent += len;
        end
    endtask

    initial begin
        for (int r = 0; r < 64; r++) begin
            real s;
            s = $sin(r + 1);
            if (s < 0.0) s = -s;
            sine_k[r] = 32'(longint'($floor(s * 4294967296.0)));
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        running <= 1'b1;

        // before any key: bytes come back unchanged; pass-through start does not rekey
        push_req(8'h00, 1'b0, 24'h0, 16'h0, 1'b0);
        push_req(8'hFF, 1'b0, 24'hFFFFFF, 16'hFFFF, 1'b0);
        push_req(8'hA5, 1'b1, 24'h000123, 16'h0007, 1'b1);
        push_req(8'h5A, 1'b0, 24'h0, 16'h0, 1'b0);
        drain();

        // 5-byte key, all-zero base, then extreme object/generation numbers
        push_req(8'h00, 1'b1, 24'h000000, 16'h0000, 1'b0);
        push_req(8'hFF, 1'b0, 24'h0, 16'h0, 1'b0);
        push_req(8'h3C, 1'b0, 24'h0, 16'h0, 1'b1);   // pass-through inside an object
        push_req(8'h00, 1'b0, 24'hFFFFFF, 16'hFFFF, 1'b0);
        push_req(8'hFF, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b0);
        push_req(8'h80, 1'b0, 24'h0, 16'h0, 1'b0);
        push_req(8'h01, 1'b1, 24'h000001, 16'h0001, 1'b1);  // pass start mid-object
        push_req(8'h7F, 1'b0, 24'h0, 16'h0, 1'b0);
        drain();

        // key registers changed mid-object: old key keeps running until next start
        write_reg(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_UNUSED, 64'h1);
        push_req(8'h11, 1'b0, 24'h0, 16'h0, 1'b0);
        push_req(8'h22, 1'b1, 24'h800000, 16'h8000, 1'b0);
        push_req(8'h33, 1'b0, 24'h0, 16'h0, 1'b0);
        drain();

        write_reg(CFG_KEY_MODE, 64'h1);
        push_req(8'hC3, 1'b0, 24'h0, 16'h0, 1'b0);
        push_req(8'hAA, 1'b1, 24'h000000, 16'h0000, 1'b0);
        push_req(8'h55, 1'b0, 24'h0, 16'h0, 1'b0);
        drain();

        // random phases across key settings; the sender holds off between them
        write_reg(CFG_KEY_MODE, 64'h0);
        write_reg(CFG_KEY_LOW, 64'h0);
        push_objects(220);
        drain();

        write_reg(CFG_KEY_LOW, rand64());
        write_reg(CFG_UNUSED, rand64());
        calm = 1'b1;
        push_objects(220);
        drain();
        calm = 1'b0;

        write_reg(CFG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_HIGH, 64'h0);
        push_objects(220);
        drain();

        write_reg(CFG_KEY_LOW, rand64());
        write_reg(CFG_KEY_HIGH, rand64());
        push_objects(220);
        drain();

        write_reg(CFG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFE);  // only bit 0 counts
        write_reg(CFG_KEY_HIGH, rand64());
        push_objects(220);
        drain();

        write_reg(CFG_KEY_MODE, 64'h1);
        write_reg(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        push_objects(220);
        drain();

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
